### rtl/core/cdq_pkg.sv
package cdq_pkg;

    // Default sizing of the ring store.
    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 32;

    // Stream payload widths: fields packed from bit 0, padded to whole bytes.
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;

    // Field widths of a request and a result.
    localparam int OPCODE_W   = 3;
    localparam int POSITION_W = 8;
    localparam int VALUE_W    = 32;
    localparam int RDATA_W    = 32;
    localparam int FOUND_W    = 8;
    localparam int COUNT_W    = 9;
    localparam int STATUS_W   = 3;

    // Operation codes carried in a request.
    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_READ       = 3'd4,
        OP_WRITE      = 3'd5,
        OP_SEARCH     = 3'd6,
        OP_CLEAR      = 3'd7
    } cdq_op_t;

    // Status codes returned with each result.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_BOUNDS    = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_EMPTY     = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } cdq_status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the incoming request
        logic exec;     // perform the latched operation
        logic step;     // advance the search walk by one entry
        logic emit;     // load the result into the output register
    } cdq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic search_go;    // latched request is a search over a non-empty deque
        logic search_done;  // search walk finishes this cycle
        logic out_free;     // output register can take a result this cycle
    } cdq_stat_t;

endpackage

### rtl/core/circular_deque_indexed.sv
// Double-ended queue in a ring store of DEPTH entries, with indexed access and search.
// Slave channel (s_*): one request per transfer naming push back/front, pop back/front,
// read or write at a logical index from the head, search for a value, or clear.
// Master channel (m_*): exactly one result per request, in request order, giving read
// data, the index found by search, the element count after the operation and a status.
// A request is latched when accepted, executed, then loaded into the output register; a
// search walks the ring store between execution and loading. The next request is accepted
// as the previous result is loaded, so executions never overlap. A search walks one entry
// per cycle through the single ring-store port with its registered read.
// Reset empties the deque (head and count to zero); store contents are not cleared and
// need no clearing pass, since only written entries can ever be read.
// When the receiver stalls, the result waits in the output register; one further
// request is accepted and executed meanwhile, and its result waits until the output
// register is taken.
module circular_deque_indexed
    import cdq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // opcode[2:0], position[10:3], value[42:11], zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // read_data[31:0], found_position[39:32],
                                           // count[48:40], status[51:49], zero pad
);

    cdq_cmd_t  cmd;
    cdq_stat_t stat;

    // Sequencing of each request.
    cdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Ring store, pointers and result register.
    cdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

### rtl/core/cdq_ctrl.sv
module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  cdq_stat_t stat,
    output cdq_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_SEARCH = 4'b0100,
        S_FINISH = 4'b1000
    } cdq_state_t;

    cdq_state_t state_reg;
    cdq_state_t state_next;

    // A new request is taken when idle, or while the finished result is handed over.
    assign s_tready = (state_reg == S_IDLE) || ((state_reg == S_FINISH) && stat.out_free);

    always_comb
    begin
        cmd.capture = s_tvalid && s_tready;
        cmd.exec    = (state_reg == S_EXEC);
        cmd.step    = (state_reg == S_SEARCH);
        cmd.emit    = (state_reg == S_FINISH) && stat.out_free;
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = stat.search_go ? S_SEARCH : S_FINISH;
            end
            S_SEARCH:
            begin
                if (stat.search_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = s_tvalid ? S_EXEC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/cdq_datapath.sv
module cdq_datapath
    import cdq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  cdq_cmd_t             cmd,
    output cdq_stat_t            stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;
    localparam int PAD_W = M_TDATA_W - RDATA_W - FOUND_W - COUNT_W - STATUS_W;

    // Ring store with one write port and one registered read port.
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] mem_q_reg;

    // Latched request.
    cdq_op_t               op_reg;
    logic [POSITION_W-1:0] pos_reg;
    logic [DATA_WIDTH-1:0] val_reg;

    // Deque state.
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // Search walk.
    logic [CNT_W-1:0] iss_idx_reg;
    logic [PTR_W-1:0] iss_slot_reg;
    logic [PTR_W-1:0] cmp_idx_reg;
    logic             pend_reg;

    // Result being built.
    cdq_status_t      status_reg;
    cdq_status_t      status_next;
    logic [PTR_W-1:0] found_reg;
    logic             rd_sel_reg;
    logic             rd_sel_next;

    // Output register.
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic             is_full;
    logic             is_empty;
    logic             in_bounds;
    logic [CNT_W-1:0] add_off;
    logic [SUM_W-1:0] add_sum;
    logic [PTR_W-1:0] add_slot;
    logic [PTR_W-1:0] head_inc;
    logic [PTR_W-1:0] head_dec;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic             hit;
    logic             more;
    logic [PTR_W-1:0] slot_step;

    // Occupancy and bounds checks.
    assign is_full   = (cnt_reg == CNT_W'(DEPTH));
    assign is_empty  = (cnt_reg == '0);
    assign in_bounds = (CMP_W'(pos_reg) < CMP_W'(cnt_reg));

    // Logical-to-physical slot: for any slot that is used, the sum stays below twice the depth.
    assign add_off  = (op_reg == OP_PUSH_BACK) ? cnt_reg : CNT_W'(pos_reg);
    assign add_sum  = SUM_W'(head_reg) + SUM_W'(add_off);
    assign add_slot = (add_sum >= SUM_W'(DEPTH)) ? PTR_W'(add_sum - SUM_W'(DEPTH))
                                                 : PTR_W'(add_sum);

    assign head_inc  = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_dec  = (head_reg == '0) ? PTR_W'(DEPTH - 1) : head_reg - 1'b1;
    assign slot_step = (iss_slot_reg == PTR_W'(DEPTH - 1)) ? '0 : iss_slot_reg + 1'b1;

    // Operation decode.
    always_comb
    begin
        head_next   = head_reg;
        cnt_next    = cnt_reg;
        status_next = STAT_OK;
        rd_sel_next = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = add_slot;
        unique case (op_reg)
            OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    wr_en     = 1'b1;
                    wr_addr   = head_dec;
                    head_next = head_dec;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            OP_POP_BACK:
            begin
                if (is_empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            OP_POP_FRONT:
            begin
                if (is_empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    head_next = head_inc;
                    cnt_next  = cnt_reg - 1'b1;
                end
            end
            OP_READ:
            begin
                if (in_bounds)
                begin
                    rd_sel_next = 1'b1;
                end
                else
                begin
                    status_next = STAT_BOUNDS;
                end
            end
            OP_WRITE:
            begin
                if (in_bounds)
                begin
                    wr_en = 1'b1;
                end
                else
                begin
                    status_next = STAT_BOUNDS;
                end
            end
            OP_SEARCH:
            begin
                status_next = STAT_NOT_FOUND;
            end
            OP_CLEAR:
            begin
                head_next = '0;
                cnt_next  = '0;
            end
        endcase
    end

    // Search walk: one read issued and one compare made per cycle.
    assign hit  = pend_reg && (mem_q_reg == val_reg);
    assign more = (iss_idx_reg < cnt_reg);

    assign rd_en   = (cmd.exec && rd_sel_next) || (cmd.step && !hit && more);
    assign rd_addr = cmd.step ? iss_slot_reg : add_slot;

    always_comb
    begin
        stat.search_go   = (op_reg == OP_SEARCH) && !is_empty;
        stat.search_done = hit || !more;
        stat.out_free    = !out_valid_reg || m_tready;
    end

    // Ring store access.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[wr_addr] <= val_reg;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // Request latch and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= cdq_op_t'(s_tdata[OPCODE_W-1:0]);
            pos_reg <= s_tdata[OPCODE_W +: POSITION_W];
            val_reg <= DATA_WIDTH'(s_tdata[OPCODE_W + POSITION_W +: VALUE_W]);
        end
        if (cmd.exec)
        begin
            status_reg   <= status_next;
            rd_sel_reg   <= rd_sel_next;
            found_reg    <= '0;
            iss_idx_reg  <= '0;
            iss_slot_reg <= head_reg;
        end
        else if (cmd.step)
        begin
            if (hit)
            begin
                status_reg <= STAT_OK;
                found_reg  <= cmp_idx_reg;
            end
            else if (more)
            begin
                cmp_idx_reg  <= PTR_W'(iss_idx_reg);
                iss_idx_reg  <= iss_idx_reg + 1'b1;
                iss_slot_reg <= slot_step;
            end
        end
        if (cmd.emit)
        begin
            out_data_reg <= {{PAD_W{1'b0}},
                             status_reg,
                             COUNT_W'(cnt_reg),
                             FOUND_W'(found_reg),
                             rd_sel_reg ? RDATA_W'(mem_q_reg) : {RDATA_W{1'b0}}};
        end
    end

    // Control state: deque pointers, compare pending flag, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                head_reg <= head_next;
                cnt_reg  <= cnt_next;
                pend_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                pend_reg <= !hit && more;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### rtl/core/cdq_checker.sv
module cdq_checker
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [RDATA_W-1:0]  res_rdata;
    logic [COUNT_W-1:0]  res_count;
    logic [STATUS_W-1:0] res_status;

    assign res_rdata  = m_tdata[RDATA_W-1:0];
    assign res_count  = m_tdata[RDATA_W + FOUND_W +: COUNT_W];
    assign res_status = m_tdata[RDATA_W + FOUND_W + COUNT_W +: STATUS_W];

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // The reported count never exceeds the depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (DEPTH < 512) |-> res_count <= COUNT_W'(DEPTH))
        else $error("count above depth");

    // A refused push means the deque is full.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (res_status == STAT_FULL) |-> res_count == COUNT_W'(DEPTH))
        else $error("full status with count below depth");

    // A refused pop means the deque is empty.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (res_status == STAT_EMPTY) |-> res_count == '0)
        else $error("empty status with nonzero count");

    // Read data is nonzero only for a successful read.
    a_rdata_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (res_rdata != '0) |-> res_status == STAT_OK)
        else $error("read data returned with error status");

endmodule

bind circular_deque_indexed cdq_checker #(
    .DEPTH (DEPTH)
) u_cdq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/sv/circular_deque_indexed_test.sv
module circular_deque_indexed_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cdq_pkg::*;

    localparam int CYCLE_LIMIT  = 5000000;
    localparam int TAIL_CYCLES  = 300;
    localparam int DIRECTED_N   = 24;
    localparam int RANDOM_PER_PHASE = 270;
    localparam int MAX_PRINTED  = 100;

    // One result as carried on the master channel.
    typedef struct packed {
        logic [RDATA_W-1:0] rdata;
        logic [FOUND_W-1:0] found;
        logic [COUNT_W-1:0] count;
        cdq_status_t        status;
    } deque_result_t;

    // One row of the directed table; typed rows carry their own expected result.
    typedef struct {
        cdq_op_t            op;
        logic [7:0]         pos;
        logic [31:0]        val;
        bit                 typed;
        deque_result_t      want;
    } stim_row_t;

    localparam deque_result_t UNTYPED = '{32'h0, 8'h0, 9'h0, STAT_OK};

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // opcode, position, value, zero pad
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // read_data, found_position, count, status, zero pad

    // Own copy of the deque contents, used to predict each result that a row does not give itself.
    logic [31:0] model_store [256];
    logic [7:0]  model_head;
    logic [8:0]  model_count;

    deque_result_t pending_results [$];
    deque_result_t observed;

    int mismatches;
    int results_checked;
    int requests_sent;
    int refused_full;
    int refused_empty;
    int search_hits;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;

    stim_row_t directed_rows [DIRECTED_N] = '{
        '{OP_POP_BACK,   8'd0,   32'h0,        1'b1, '{32'h0, 8'h0, 9'd0, STAT_EMPTY}},
        '{OP_POP_FRONT,  8'd0,   32'h0,        1'b1, '{32'h0, 8'h0, 9'd0, STAT_EMPTY}},
        '{OP_READ,       8'd0,   32'h0,        1'b1, '{32'h0, 8'h0, 9'd0, STAT_BOUNDS}},
        '{OP_WRITE,      8'd0,   32'h5,        1'b1, '{32'h0, 8'h0, 9'd0, STAT_BOUNDS}},
        '{OP_SEARCH,     8'd0,   32'h0,        1'b1, '{32'h0, 8'h0, 9'd0, STAT_NOT_FOUND}},
        '{OP_PUSH_BACK,  8'd0,   32'h7FFFFFFF, 1'b1, '{32'h0, 8'h0, 9'd1, STAT_OK}},
        '{OP_PUSH_FRONT, 8'd0,   32'h80000000, 1'b1, '{32'h0, 8'h0, 9'd2, STAT_OK}},
        '{OP_PUSH_BACK,  8'd0,   32'hFFFFFFFF, 1'b1, '{32'h0, 8'h0, 9'd3, STAT_OK}},
        '{OP_READ,       8'd0,   32'h0,        1'b0, UNTYPED},
        '{OP_READ,       8'd2,   32'h0,        1'b0, UNTYPED},
        '{OP_READ,       8'd255, 32'h0,        1'b1, '{32'h0, 8'h0, 9'd3, STAT_BOUNDS}},
        '{OP_READ,       8'd3,   32'h0,        1'b1, '{32'h0, 8'h0, 9'd3, STAT_BOUNDS}},
        '{OP_WRITE,      8'd1,   32'h0,        1'b0, UNTYPED},
        '{OP_WRITE,      8'd255, 32'hA5A5A5A5, 1'b1, '{32'h0, 8'h0, 9'd3, STAT_BOUNDS}},
        '{OP_SEARCH,     8'd0,   32'h0,        1'b0, UNTYPED},
        '{OP_SEARCH,     8'd0,   32'hFFFFFFFF, 1'b0, UNTYPED},
        '{OP_SEARCH,     8'd0,   32'h12345678, 1'b0, UNTYPED},
        '{OP_POP_FRONT,  8'd0,   32'h0,        1'b0, UNTYPED},
        '{OP_POP_BACK,   8'd0,   32'h0,        1'b0, UNTYPED},
        '{OP_READ,       8'd0,   32'h0,        1'b0, UNTYPED},
        '{OP_CLEAR,      8'd255, 32'hFFFFFFFF, 1'b1, '{32'h0, 8'h0, 9'd0, STAT_OK}},
        '{OP_READ,       8'd0,   32'h0,        1'b1, '{32'h0, 8'h0, 9'd0, STAT_BOUNDS}},
        '{OP_PUSH_FRONT, 8'd0,   32'h1,        1'b1, '{32'h0, 8'h0, 9'd1, STAT_OK}},
        '{OP_POP_FRONT,  8'd0,   32'h0,        1'b1, '{32'h0, 8'h0, 9'd0, STAT_OK}}
    };

    circular_deque_indexed dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock, 20 ns period.
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run guard: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t: result %0d, %s: got %0h, expected %0h",
                     $realtime, results_checked, what, got, want);
    endtask

    // Applies one operation to the local deque copy and returns its result.
    task automatic apply_deque_op(input cdq_op_t op, input logic [7:0] pos,
                                  input logic [31:0] val, output deque_result_t res);
        logic [8:0] idx;
        bit         hit;
        res = '{32'h0, 8'h0, 9'h0, STAT_OK};
        hit = 1'b0;
        case (op) inside
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (model_count == 9'd256)
                begin
                    res.status = STAT_FULL;
                    refused_full++;
                end
                else if (op == OP_PUSH_BACK)
                begin
                    model_store[model_head + model_count[7:0]] = val;
                    model_count++;
                end
                else
                begin
                    model_head = model_head - 8'd1;
                    model_store[model_head] = val;
                    model_count++;
                end
            end
            OP_POP_BACK, OP_POP_FRONT:
            begin
                if (model_count == 9'd0)
                begin
                    res.status = STAT_EMPTY;
                    refused_empty++;
                end
                else
                begin
                    if (op == OP_POP_FRONT)
                        model_head = model_head + 8'd1;
                    model_count--;
                end
            end
            OP_READ:
            begin
                if ({1'b0, pos} >= model_count)
                    res.status = STAT_BOUNDS;
                else
                    res.rdata = model_store[model_head + pos];
            end
            OP_WRITE:
            begin
                if ({1'b0, pos} >= model_count)
                    res.status = STAT_BOUNDS;
                else
                    model_store[model_head + pos] = val;
            end
            OP_SEARCH:
            begin
                res.status = STAT_NOT_FOUND;
                for (idx = 9'd0; idx < model_count && !hit; idx++)
                begin
                    if (model_store[model_head + idx[7:0]] == val)
                    begin
                        hit = 1'b1;
                        res.found = idx[7:0];
                        res.status = STAT_OK;
                        search_hits++;
                    end
                end
            end
            default:
            begin
                model_head = 8'd0;
                model_count = 9'd0;
            end
        endcase
        res.count = model_count;
    endtask

    // Offers one request, waits for its acceptance and queues the expected result.
    task automatic send_request(input cdq_op_t op, input logic [7:0] pos,
                                input logic [31:0] val, input bit typed,
                                input deque_result_t typed_want);
        deque_result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, val, pos, op};
        do
            @(posedge clk);
        while (!s_tready);
        apply_deque_op(op, pos, val, predicted);
        pending_results.push_back(typed ? typed_want : predicted);
        requests_sent++;
        @(negedge clk);
    endtask

    // Chooses a random request, steering the fill level toward a moving target.
    task automatic pick_random_request(input int target, output cdq_op_t op,
                                       output logic [7:0] pos, output logic [31:0] val);
        int  roll;
        bit  grow;
        roll = $urandom_range(99);
        grow = (model_count < target);
        if (roll < 2)
            op = OP_CLEAR;
        else if (roll < 40)
            op = grow ? ($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT)
                      : ($urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT);
        else if (roll < 52)
            op = grow ? ($urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT)
                      : ($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT);
        else if (roll < 67)
            op = OP_READ;
        else if (roll < 79)
            op = OP_WRITE;
        else if (roll < 95)
            op = OP_SEARCH;
        else
            op = cdq_op_t'($urandom_range(7));

        if (model_count != 0 && $urandom_range(9) < 8)
            pos = 8'($urandom_range(int'(model_count) - 1));
        else
            pos = 8'($urandom_range(255));

        // Small values repeat often, so searches find earlier duplicates.
        if ($urandom_range(3) == 0)
            val = 32'($urandom_range(15));
        else
            val = $urandom();
        if (op == OP_SEARCH && model_count != 0 && $urandom_range(9) < 6)
            val = model_store[model_head + 8'($urandom_range(int'(model_count) - 1))];
    endtask

    // Receiver: stalls at random according to the current phase.
    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            observed.rdata  = m_tdata[RDATA_W-1:0];
            observed.found  = m_tdata[RDATA_W +: FOUND_W];
            observed.count  = m_tdata[RDATA_W + FOUND_W +: COUNT_W];
            observed.status = cdq_status_t'(m_tdata[RDATA_W + FOUND_W + COUNT_W +: STATUS_W]);
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", m_tdata, 0);
            else
            begin
                deque_result_t want;
                want = pending_results.pop_front();
                if (observed.rdata !== want.rdata)
                    report_mismatch("read_data", observed.rdata, want.rdata);
                if (observed.found !== want.found)
                    report_mismatch("found_position", observed.found, want.found);
                if (observed.count !== want.count)
                    report_mismatch("count", observed.count, want.count);
                if (observed.status !== want.status)
                    report_mismatch("status", observed.status, want.status);
                if (m_tdata[M_TDATA_W-1:RDATA_W+FOUND_W+COUNT_W+STATUS_W] !== '0)
                    report_mismatch("pad bits", m_tdata, 0);
                results_checked++;
            end
        end
    end

    // Stimulus: directed table, fill and drain, then random phases.
    initial
    begin
        cdq_op_t     op;
        logic [7:0]  pos;
        logic [31:0] val;
        int          target;
        int          phase;
        int          n;
        int          phase_idle [4];
        int          phase_stall [4];
        phase_idle  = '{0, 64, 0, 33};
        phase_stall = '{0, 0, 64, 33};
        mismatches = 0;
        results_checked = 0;
        requests_sent = 0;
        refused_full = 0;
        refused_empty = 0;
        search_hits = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        model_head = 8'd0;
        model_count = 9'd0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rows from the table.
        for (n = 0; n < DIRECTED_N; n++)
            send_request(directed_rows[n].op, directed_rows[n].pos, directed_rows[n].val,
                         directed_rows[n].typed, directed_rows[n].want);

        // Fill to capacity from both ends, probe the full deque, then drain it.
        for (n = 0; n < 256; n++)
            send_request((n % 2 == 0) ? OP_PUSH_BACK : OP_PUSH_FRONT, 8'd0, $urandom(),
                         1'b0, UNTYPED);
        send_request(OP_PUSH_BACK, 8'd0, 32'h0, 1'b1, '{32'h0, 8'h0, 9'd256, STAT_FULL});
        send_request(OP_PUSH_FRONT, 8'd0, 32'h0, 1'b1, '{32'h0, 8'h0, 9'd256, STAT_FULL});
        send_request(OP_READ, 8'd255, 32'h0, 1'b0, UNTYPED);
        send_request(OP_READ, 8'd0, 32'h0, 1'b0, UNTYPED);
        send_request(OP_WRITE, 8'd255, 32'h5A5A0F0F, 1'b0, UNTYPED);
        send_request(OP_SEARCH, 8'd0, 32'h5A5A0F0F, 1'b0, UNTYPED);
        send_request(OP_SEARCH, 8'd0, ~model_store[model_head], 1'b0, UNTYPED);
        for (n = 0; n < 256; n++)
            send_request((n % 2 == 0) ? OP_POP_FRONT : OP_POP_BACK, 8'd0, 32'h0,
                         1'b0, UNTYPED);
        send_request(OP_POP_BACK, 8'd0, 32'h0, 1'b1, '{32'h0, 8'h0, 9'd0, STAT_EMPTY});

        // Random phases, each with its own idling pattern.
        target = 8;
        for (phase = 0; phase < 4; phase++)
        begin
            // Hold off until every outstanding result has come back.
            s_tvalid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
            @(negedge clk);
            send_idle_pct = phase_idle[phase];
            recv_stall_pct = phase_stall[phase];
            for (n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (n % 64 == 0)
                begin
                    case ($urandom_range(4))
                        0: target = 1;
                        1: target = 8;
                        2: target = 64;
                        3: target = 200;
                        default: target = 256;
                    endcase
                end
                pick_random_request(target, op, pos, val);
                send_request(op, pos, val, 1'b0, UNTYPED);
            end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then allow time for anything stray.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d requests over four idling phases; %0d results compared.",
                 requests_sent, results_checked);
        $display("Refused pushes: %0d, refused pops: %0d, searches that matched: %0d.",
                 refused_full, refused_empty, search_hits);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
rtl/core/cdq_pkg.sv
rtl/core/cdq_ctrl.sv
rtl/core/cdq_datapath.sv
rtl/core/circular_deque_indexed.sv
rtl/core/cdq_checker.sv
tb/sv/circular_deque_indexed_test.sv
